@@ src/kfrl_pkg.sv @@
// kfrl_pkg: shared types, constants and codes for the keyed fixed-window rate limiter
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package kfrl_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int OCC_W         = 13;
  localparam int CFG_W         = 17;
  localparam int CFG_IDX_W     = 2;
  localparam int IN_TDATA_W    = 72;
  localparam int OUT_TDATA_W   = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TTL  = 2'd2;

  // request modes
  localparam logic [1:0] MODE_CHECK = 2'd0;
  localparam logic [1:0] MODE_PRUNE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_ALLOWED = 2'd0;
  localparam logic [1:0] ST_LIMITED = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_MAINT   = 2'd3;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] win_begin;
    logic [15:0] count;
    logic [31:0] seen_at;
  } ent_t;

  typedef struct packed {
    logic [OCC_W-1:0] occupancy;
    logic [16:0]      retry_wait;
    logic [15:0]      remaining;
    logic [1:0]       status;
  } res_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              v_we;
    logic              v_wdata;
    logic              d_we;
    logic [ADDR_W-1:0] waddr;
    ent_t              d_wdata;
  } mreq_t;

  typedef struct packed {
    logic v;
    ent_t ent;
  } mrsp_t;

endpackage

@@ src/kfrl_mem.sv @@
// kfrl_mem: slot table storage, a valid-bit memory and an entry memory
// one write and one registered read per cycle; uses kfrl_pkg
`timescale 1ns / 1ps

module kfrl_mem (
  input  logic           clk,
  input  kfrl_pkg::mreq_t req,
  output kfrl_pkg::mrsp_t rsp
);
  import kfrl_pkg::*;

  logic valid_mem [TABLE_ENTRIES];
  ent_t ent_mem   [TABLE_ENTRIES];
  logic v_q_r;
  ent_t ent_q_r;

  always_ff @(posedge clk) begin
    if (req.v_we) begin
      valid_mem[req.waddr] <= req.v_wdata;
    end
    if (req.d_we) begin
      ent_mem[req.waddr] <= req.d_wdata;
    end
    if (req.rd_en) begin
      v_q_r   <= valid_mem[req.rd_addr];
      ent_q_r <= ent_mem[req.rd_addr];
    end
  end

  assign rsp.v   = v_q_r;
  assign rsp.ent = ent_q_r;

endmodule

@@ src/kfrl_ctrl.sv @@
// kfrl_ctrl: sequencer that scans, prunes, evicts and updates the slot table
// drives kfrl_mem through mreq_t; uses kfrl_pkg
`timescale 1ns / 1ps

module kfrl_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [31:0]                   in_key,
  input  logic [31:0]                   in_now,
  input  logic [15:0]                   attempt_limit,
  input  logic [16:0]                   window_seconds,
  input  logic [16:0]                   idle_ttl_seconds,
  output kfrl_pkg::mreq_t               mreq,
  input  kfrl_pkg::mrsp_t               mrsp,
  output logic                          res_valid,
  input  logic                          res_ready,
  output kfrl_pkg::res_t                res
);
  import kfrl_pkg::*;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PRUNE = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_EVWR  = 3'd4;
  localparam logic [2:0] S_LOOK  = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  FULL = CNT_W'(TABLE_ENTRIES);

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [ADDR_W-1:0] iss_idx_r, iss_idx_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic              p_vld_r, p_vld_nxt;
  logic [ADDR_W-1:0] p_addr_r, p_addr_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] best_addr_r, best_addr_nxt;
  logic [31:0]       best_ls_r, best_ls_nxt;
  logic              hit_r, hit_nxt;
  logic [ADDR_W-1:0] hit_addr_r, hit_addr_nxt;
  ent_t              hit_ent_r, hit_ent_nxt;
  logic              free_r, free_nxt;
  logic [ADDR_W-1:0] free_addr_r, free_addr_nxt;
  logic              clr_resp_r, clr_resp_nxt;
  res_t              res_r, res_nxt;

  logic              scanning, last;
  logic [31:0]       idle_age;
  ent_t              base;
  logic [31:0]       el0, el1;
  logic              restart, limited;
  logic [31:0]       ws2;
  logic [15:0]       cnt2;

  assign scanning = (state_r == S_PRUNE) || (state_r == S_EVICT) || (state_r == S_LOOK);
  assign last     = p_vld_r && (p_addr_r == LAST);
  assign idle_age = now_r - mrsp.ent.seen_at;

  // slot update arithmetic
  always_comb begin
    base     = hit_r ? hit_ent_r : '0;
    el0      = now_r - base.win_begin;
    restart  = (base.count == 16'd0) || (el0 >= {15'd0, window_seconds});
    ws2      = restart ? now_r : base.win_begin;
    cnt2     = restart ? 16'd0 : base.count;
    el1      = now_r - ws2;
    limited  = cnt2 >= attempt_limit;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    used_nxt      = used_r;
    iss_idx_nxt   = iss_idx_r;
    iss_done_nxt  = iss_done_r;
    found_nxt     = found_r;
    best_addr_nxt = best_addr_r;
    best_ls_nxt   = best_ls_r;
    hit_nxt       = hit_r;
    hit_addr_nxt  = hit_addr_r;
    hit_ent_nxt   = hit_ent_r;
    free_nxt      = free_r;
    free_addr_nxt = free_addr_r;
    clr_resp_nxt  = clr_resp_r;
    res_nxt       = res_r;
    mreq          = '0;
    in_ready      = 1'b0;
    res_valid     = 1'b0;

    // shared read pipeline for the scans
    mreq.rd_en   = scanning && !iss_done_r;
    mreq.rd_addr = iss_idx_r;
    p_vld_nxt    = mreq.rd_en;
    p_addr_nxt   = iss_idx_r;
    if (mreq.rd_en) begin
      iss_idx_nxt  = iss_idx_r + ADDR_W'(1);
      iss_done_nxt = (iss_idx_r == LAST);
    end

    case (state_r)
      S_CLR: begin
        mreq.v_we    = 1'b1;
        mreq.v_wdata = 1'b0;
        mreq.waddr   = iss_idx_r;
        iss_idx_nxt  = iss_idx_r + ADDR_W'(1);
        if (iss_idx_r == LAST) begin
          used_nxt     = '0;
          iss_idx_nxt  = '0;
          state_nxt    = clr_resp_r ? S_RESP : S_IDLE;
          res_nxt      = '0;
          res_nxt.status = ST_MAINT;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt     = in_mode;
          key_nxt      = in_key;
          now_nxt      = in_now;
          iss_idx_nxt  = '0;
          iss_done_nxt = 1'b0;
          found_nxt    = 1'b0;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          res_nxt      = '0;
          res_nxt.occupancy = OCC_W'(used_r);
          case (in_mode)
            MODE_CHECK: begin
              if (in_key == 32'd0 || attempt_limit == 16'd0 || window_seconds == 17'd0) begin
                res_nxt.status = ST_INVALID;
                state_nxt      = S_RESP;
              end else if (used_r >= FULL) begin
                state_nxt = S_PRUNE;
              end else begin
                state_nxt = S_LOOK;
              end
            end
            MODE_PRUNE: state_nxt = S_PRUNE;
            MODE_CLEAR: begin
              clr_resp_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            default: begin
              res_nxt.status = ST_MAINT;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end
      S_PRUNE: begin
        if (p_vld_r && mrsp.v && (idle_age >= {15'd0, idle_ttl_seconds})) begin
          mreq.v_we    = 1'b1;
          mreq.v_wdata = 1'b0;
          mreq.waddr   = p_addr_r;
          used_nxt     = used_r - CNT_W'(1);
        end
        if (last) begin
          iss_idx_nxt  = '0;
          iss_done_nxt = 1'b0;
          if (mode_r == MODE_PRUNE) begin
            res_nxt.status    = ST_MAINT;
            res_nxt.occupancy = OCC_W'(used_nxt);
            state_nxt         = S_RESP;
          end else if (used_nxt >= FULL) begin
            state_nxt = S_EVICT;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_EVICT: begin
        if (p_vld_r && mrsp.v && (!found_r || mrsp.ent.seen_at < best_ls_r)) begin
          found_nxt     = 1'b1;
          best_addr_nxt = p_addr_r;
          best_ls_nxt   = mrsp.ent.seen_at;
        end
        if (last) begin
          state_nxt = S_EVWR;
        end
      end
      S_EVWR: begin
        if (found_r) begin
          mreq.v_we    = 1'b1;
          mreq.v_wdata = 1'b0;
          mreq.waddr   = best_addr_r;
          used_nxt     = used_r - CNT_W'(1);
        end
        iss_idx_nxt  = '0;
        iss_done_nxt = 1'b0;
        state_nxt    = S_LOOK;
      end
      S_LOOK: begin
        if (p_vld_r) begin
          if (mrsp.v) begin
            if (mrsp.ent.key == key_r) begin
              hit_nxt      = 1'b1;
              hit_addr_nxt = p_addr_r;
              hit_ent_nxt  = mrsp.ent;
            end
          end else if (!free_r) begin
            free_nxt      = 1'b1;
            free_addr_nxt = p_addr_r;
          end
        end
        if (last) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        mreq.v_we    = 1'b1;
        mreq.v_wdata = 1'b1;
        mreq.d_we    = 1'b1;
        mreq.waddr   = hit_r ? hit_addr_r : free_addr_r;
        mreq.d_wdata.key       = key_r;
        mreq.d_wdata.win_begin = ws2;
        mreq.d_wdata.count     = limited ? cnt2 : cnt2 + 16'd1;
        mreq.d_wdata.seen_at   = now_r;
        if (!hit_r) begin
          used_nxt = used_r + CNT_W'(1);
        end
        res_nxt.occupancy = OCC_W'(used_nxt);
        if (limited) begin
          res_nxt.status     = ST_LIMITED;
          res_nxt.remaining  = '0;
          res_nxt.retry_wait = (el1 >= {15'd0, window_seconds}) ? 17'd0
                               : window_seconds - el1[16:0];
        end else begin
          res_nxt.status     = ST_ALLOWED;
          res_nxt.remaining  = attempt_limit - cnt2 - 16'd1;
          res_nxt.retry_wait = '0;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          clr_resp_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      used_r     <= '0;
      iss_idx_r  <= '0;
      iss_done_r <= 1'b0;
      p_vld_r    <= 1'b0;
      clr_resp_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      iss_idx_r  <= iss_idx_nxt;
      iss_done_r <= iss_done_nxt;
      p_vld_r    <= p_vld_nxt;
      clr_resp_r <= clr_resp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    key_r       <= key_nxt;
    now_r       <= now_nxt;
    p_addr_r    <= p_addr_nxt;
    found_r     <= found_nxt;
    best_addr_r <= best_addr_nxt;
    best_ls_r   <= best_ls_nxt;
    hit_r       <= hit_nxt;
    hit_addr_r  <= hit_addr_nxt;
    hit_ent_r   <= hit_ent_nxt;
    free_r      <= free_nxt;
    free_addr_r <= free_addr_nxt;
    res_r       <= res_nxt;
  end

endmodule

@@ src/keyed_fixed_window_rate_limiter_top.sv @@
// keyed_fixed_window_rate_limiter_top: stream ports, config registers, result register
// instantiates kfrl_ctrl and kfrl_mem; uses kfrl_pkg
`timescale 1ns / 1ps

// Per-key fixed-window limiter over a 4096-slot table held in synchronous memory.
// Each request is one of: check an attempt for a key at a given time, prune idle
// entries, clear the table, or no operation; each request gives exactly one result.
// Requests are handled one at a time by a sequencer that sweeps the table through
// a single registered read port with one write port beside it. A check on a table
// that is not full does one lookup sweep plus the slot update; a check on a full
// table adds a prune sweep and possibly an eviction sweep. A prune does one sweep,
// a clear one pass over the valid bits; an invalid check or an unused mode goes
// straight to its result. After reset a clearing pass zeroes the valid bits; no
// request is taken during it, though config writes are. The result sits in an output
// register, so a new request is taken while the previous result waits. Config writes
// are meant to happen only while the block is idle.

module keyed_fixed_window_rate_limiter_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // mode[1:0], key[33:2], now[65:34], zero pad
  input  logic [kfrl_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // status[1:0], remaining[17:2], retry_wait[34:18], occupancy[47:35]
  output logic [kfrl_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_we,
  input  logic [kfrl_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [kfrl_pkg::CFG_W-1:0]            cfg_wdata
);
  import kfrl_pkg::*;

  logic [15:0] attempt_limit_r;
  logic [16:0] window_r;
  logic [16:0] idle_ttl_r;
  logic        out_vld_r, out_vld_nxt;
  res_t        out_res_r;

  mreq_t mreq;
  mrsp_t mrsp;
  logic  res_valid, res_ready;
  res_t  res;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attempt_limit_r <= 16'd5;
      window_r        <= 17'd60;
      idle_ttl_r      <= 17'd1800;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ATT_LIMIT: attempt_limit_r <= cfg_wdata[15:0];
        REG_WINDOW:    window_r        <= cfg_wdata;
        REG_IDLE_TTL:  idle_ttl_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  kfrl_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_mode          (in_tdata[1:0]),
    .in_key           (in_tdata[33:2]),
    .in_now           (in_tdata[65:34]),
    .attempt_limit    (attempt_limit_r),
    .window_seconds   (window_r),
    .idle_ttl_seconds (idle_ttl_r),
    .mreq             (mreq),
    .mrsp             (mrsp),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  kfrl_mem u_mem (
    .clk (clk),
    .req (mreq),
    .rsp (mrsp)
  );

  // output register: takes a new result when empty or being drained
  assign res_ready = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r;

endmodule

@@ src/kfrl_checker.sv @@
// kfrl_checker: port-level assertions for the rate limiter top level
// bound to keyed_fixed_window_rate_limiter_top; uses kfrl_pkg
`timescale 1ns / 1ps

module kfrl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [kfrl_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import kfrl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an allowed request never carries a retry delay
  a_allowed_no_retry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_ALLOWED) |-> (out_tdata[34:18] == 17'd0))
    else $error("allowed result with retry delay");

  // a limited request never reports remaining attempts
  a_limited_no_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_LIMITED) |-> (out_tdata[17:2] == 16'd0))
    else $error("limited result with remaining attempts");

  // occupancy never exceeds the table
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[47:35] <= 13'(TABLE_ENTRIES)))
    else $error("occupancy above table size");

endmodule

bind keyed_fixed_window_rate_limiter_top kfrl_checker u_kfrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
